### rtl/core/lzwe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzwe_pkg
// Shared types and constants of the LZW encoder.
// ----------------------------------------------------------------------------
package lzwe_pkg;

    localparam int FIRST_FREE_CODE = 256;
    localparam int BYTE_BITS       = 8;

    typedef struct packed {
        logic [BYTE_BITS-1:0] data_byte;
        logic                 eom;
        logic                 first;
    } t_item;

    typedef struct packed {
        logic busy;
        logic dict_full;
    } t_stat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_NODE,
        S_MISS,
        S_INS2,
        S_EMITL
    } t_state;

endpackage
`default_nettype wire

### rtl/core/lzwe_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzwe_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

### rtl/core/lzwe_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzwe_front
// Input side: accepts bytes, tags the first byte of each message and holds
// them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module lzwe_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_end_of_message,
    output logic                o_stall,
    output lzwe_pkg::t_item     o_item,
    output logic                o_item_valid,
    input  wire logic           i_pop
);

    lzwe_pkg::t_item r_mem [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            r_first;
    logic            acc;

    assign o_stall      = (r_cnt == 2'd2);
    assign acc          = i_valid && !o_stall;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_cnt   <= 2'd0;
            r_first <= 1'b1;
        end else begin
            if (acc) begin
                r_wp    <= !r_wp;
                r_first <= i_end_of_message;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(acc) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_mem[r_wp] <= '{data_byte: i_data_byte, eom: i_end_of_message,
                             first: r_first};
        end
    end

endmodule
`default_nettype wire

### rtl/core/lzwe_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzwe_back
// Dictionary engine: child/sibling trie search, insert and code output.
// ----------------------------------------------------------------------------
module lzwe_back #(
    parameter int CODE_BITS = 12
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire lzwe_pkg::t_item      i_item,
    input  wire logic                 i_item_valid,
    output logic                      o_pop,
    output logic                      o_valid,
    output logic [CODE_BITS-1:0]      o_code_out,
    output logic                      o_last_code,
    input  wire logic                 i_stall,
    output lzwe_pkg::t_stat           o_stat
);

    localparam int DEPTH = 1 << CODE_BITS;
    localparam logic [CODE_BITS:0] DICT_N = {1'b1, {CODE_BITS{1'b0}}};
    localparam logic [CODE_BITS:0] FF_N   = (CODE_BITS+1)'(lzwe_pkg::FIRST_FREE_CODE);
    localparam int NW = CODE_BITS + 8;

    lzwe_pkg::t_state    r_state, n_state;
    logic [CODE_BITS-1:0] r_prefix, n_prefix;
    logic [CODE_BITS:0]   r_nf, n_nf;
    logic [255:0]         r_hv, n_hv;
    logic [7:0]           r_byte, n_byte;
    logic                 r_eom, n_eom;
    logic [CODE_BITS-1:0] r_head, n_head;
    logic [CODE_BITS-1:0] r_ptr, n_ptr;
    logic                 r_ov, n_ov;
    logic [CODE_BITS-1:0] r_code, n_code;
    logic                 r_last, n_last;

    logic                 head_we, head_re, node_we, node_re;
    logic [CODE_BITS-1:0] head_waddr, head_wdata, head_raddr, head_rdata;
    logic [CODE_BITS-1:0] node_waddr, node_raddr;
    logic [NW-1:0]        node_wdata, node_rdata;
    logic [7:0]           nd_byte;
    logic [CODE_BITS-1:0] nd_sib;
    logic                 ofree, full, small_pfx;
    logic [CODE_BITS-1:0] byte_code;

    lzwe_ram #(.WIDTH(CODE_BITS), .DEPTH(DEPTH)) u_head (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_waddr), .i_wdata(head_wdata),
        .i_re(head_re), .i_raddr(head_raddr), .o_rdata(head_rdata)
    );

    lzwe_ram #(.WIDTH(NW), .DEPTH(DEPTH)) u_node (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(node_waddr), .i_wdata(node_wdata),
        .i_re(node_re), .i_raddr(node_raddr), .o_rdata(node_rdata)
    );

    assign {nd_byte, nd_sib} = node_rdata;
    assign ofree     = !r_ov || !i_stall;
    assign full      = (r_nf == DICT_N);
    assign small_pfx = (r_prefix[CODE_BITS-1:8] == '0);
    assign byte_code = {{(CODE_BITS-8){1'b0}}, r_byte};

    assign o_valid     = r_ov;
    assign o_code_out  = r_code;
    assign o_last_code = r_last;
    assign o_stat      = '{busy: (r_state != lzwe_pkg::S_IDLE), dict_full: full};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lzwe_pkg::S_IDLE;
            r_prefix <= '0;
            r_nf     <= FF_N;
            r_hv     <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_prefix <= n_prefix;
            r_nf     <= n_nf;
            r_hv     <= n_hv;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_eom  <= n_eom;
        r_head <= n_head;
        r_ptr  <= n_ptr;
        r_code <= n_code;
        r_last <= n_last;
    end

    always_comb begin
        n_state    = r_state;
        n_prefix   = r_prefix;
        n_nf       = r_nf;
        n_hv       = r_hv;
        n_byte     = r_byte;
        n_eom      = r_eom;
        n_head     = r_head;
        n_ptr      = r_ptr;
        n_ov       = r_ov && i_stall;
        n_code     = r_code;
        n_last     = r_last;
        o_pop      = 1'b0;
        head_we    = 1'b0;
        head_waddr = r_prefix;
        head_wdata = r_nf[CODE_BITS-1:0];
        head_re    = 1'b0;
        head_raddr = r_prefix;
        node_we    = 1'b0;
        node_waddr = r_nf[CODE_BITS-1:0];
        node_wdata = {r_byte, r_head};
        node_re    = 1'b0;
        node_raddr = head_rdata;
        unique case (r_state)
            lzwe_pkg::S_IDLE: begin
                if (i_item_valid) begin
                    o_pop  = 1'b1;
                    n_byte = i_item.data_byte;
                    n_eom  = i_item.eom;
                    if (i_item.first) begin
                        n_prefix = {{(CODE_BITS-8){1'b0}}, i_item.data_byte};
                        n_state  = i_item.eom ? lzwe_pkg::S_EMITL : lzwe_pkg::S_IDLE;
                    end else if (small_pfx && !r_hv[r_prefix[7:0]]) begin
                        n_head  = '0;
                        n_state = lzwe_pkg::S_MISS;
                    end else begin
                        head_re = 1'b1;
                        n_state = lzwe_pkg::S_HEAD;
                    end
                end
            end
            lzwe_pkg::S_HEAD: begin
                n_head = head_rdata;
                n_ptr  = head_rdata;
                if (head_rdata == '0) begin
                    n_state = lzwe_pkg::S_MISS;
                end else begin
                    node_re = 1'b1;
                    n_state = lzwe_pkg::S_NODE;
                end
            end
            lzwe_pkg::S_NODE: begin
                if (nd_byte == r_byte) begin
                    n_prefix = r_ptr;
                    n_state  = r_eom ? lzwe_pkg::S_EMITL : lzwe_pkg::S_IDLE;
                end else if (nd_sib == '0) begin
                    n_state = lzwe_pkg::S_MISS;
                end else begin
                    node_re    = 1'b1;
                    node_raddr = nd_sib;
                    n_ptr      = nd_sib;
                end
            end
            lzwe_pkg::S_MISS: begin
                if (ofree) begin
                    n_ov   = 1'b1;
                    n_code = r_prefix;
                    n_last = 1'b0;
                    if (!full) begin
                        node_we = 1'b1;
                        head_we = 1'b1;
                        if (small_pfx) begin
                            n_hv[r_prefix[7:0]] = 1'b1;
                        end
                        n_state = lzwe_pkg::S_INS2;
                    end else begin
                        n_prefix = byte_code;
                        n_state  = r_eom ? lzwe_pkg::S_EMITL : lzwe_pkg::S_IDLE;
                    end
                end
            end
            lzwe_pkg::S_INS2: begin
                head_we    = 1'b1;
                head_waddr = r_nf[CODE_BITS-1:0];
                head_wdata = '0;
                n_nf       = r_nf + 1'b1;
                n_prefix   = byte_code;
                n_state    = r_eom ? lzwe_pkg::S_EMITL : lzwe_pkg::S_IDLE;
            end
            lzwe_pkg::S_EMITL: begin
                if (ofree) begin
                    n_ov     = 1'b1;
                    n_code   = r_prefix;
                    n_last   = 1'b1;
                    n_prefix = '0;
                    n_nf     = FF_N;
                    n_hv     = '0;
                    n_state  = lzwe_pkg::S_IDLE;
                end
            end
            default: n_state = lzwe_pkg::S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

### rtl/core/lzw_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzw_encoder
// LZW compression encoder, one message byte per input transfer.
//
// Input channel: i_valid / o_stall carry i_data_byte and i_end_of_message.
// Output channel: o_valid / i_stall carry o_code_out and o_last_code.
// A byte that does not extend the prefix to a dictionary entry yields one
// code; the byte flagged end_of_message also yields the final code.
// Steps: the first byte of a message only sets the prefix; other bytes read
// the head RAM, then check the first child and its siblings in the trie node
// RAM until a hit. A miss adds an emit and, unless the dictionary is full, an
// insert; a prefix with no children misses after the head read, or at once
// if a byte code. End of message adds a final emit. Sibling walks dominate.
// A code is valid the cycle after the engine emits it.
// A two-entry input queue and a one-entry output register let either side
// stall; while the receiver stalls, the engine waits when it must emit.
// Reset (synchronous, active low) empties the queues and starts a fresh
// dictionary; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module lzw_encoder #(
    parameter int CODE_BITS = 12
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic                 i_end_of_message,
    output logic                      o_stall,
    output logic                      o_valid,
    output logic [CODE_BITS-1:0]      o_code_out,
    output logic                      o_last_code,
    input  wire logic                 i_stall
);

    lzwe_pkg::t_item item;
    lzwe_pkg::t_stat stat;
    logic            item_valid;
    logic            pop;

    lzwe_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid),
        .i_data_byte(i_data_byte), .i_end_of_message(i_end_of_message),
        .o_stall(o_stall), .o_item(item), .o_item_valid(item_valid), .i_pop(pop)
    );

    lzwe_back #(.CODE_BITS(CODE_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(item), .i_item_valid(item_valid),
        .o_pop(pop), .o_valid(o_valid), .o_code_out(o_code_out),
        .o_last_code(o_last_code), .i_stall(i_stall), .o_stat(stat)
    );

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> item_valid && !stat.busy)
        else $error("pop from empty queue or busy engine");

    a_reset_dict: assert property (@(posedge i_clk)
        !i_rst_n |=> !stat.dict_full && !o_valid)
        else $error("dictionary not fresh after reset");

endmodule
`default_nettype wire

### test/lzw_encoder_tb.sv
// ----------------------------------------------------------------------------
// lzw_encoder_tb
// Self-checking bench for the LZW encoder: random and directed messages,
// a local dictionary predictor, code-by-code compare under random stalls.
// ----------------------------------------------------------------------------
module lzw_encoder_tb;

    localparam int CB   = 12;
    localparam int DSZ  = 1 << CB;
    localparam int FREE = lzwe_pkg::FIRST_FREE_CODE;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       eom;
    } t_byte_in;

    typedef struct packed {
        logic [CB-1:0] code;
        logic          last;
    } t_code_out;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic [7:0]    i_data_byte = '0;
    logic          i_end_of_message = 1'b0;
    logic          o_stall;
    logic          o_valid;
    logic [CB-1:0] o_code_out;
    logic          o_last_code;
    logic          i_stall = 1'b0;

    lzw_encoder #(.CODE_BITS(CB)) i_dut (.*);

    t_byte_in  byte_q[$];
    t_code_out code_q[$];
    int        errors = 0;
    int        src_idle = 35;
    int        snk_idle = 62;
    bit        hold_src = 1'b0;

    logic [CB-1:0] pfx;
    logic          pfx_ok;
    int            next_code;
    logic [CB+7:0] dict [DSZ];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic lzw_clear();
        pfx = '0;
        pfx_ok = 1'b0;
        next_code = FREE;
    endtask

    task automatic lzw_predict(input t_byte_in b);
        int hit;
        hit = -1;
        if (!pfx_ok) begin
            pfx = CB'(b.data_byte);
            pfx_ok = 1'b1;
        end else begin
            for (int c = FREE; c < next_code; c++) begin
                if (dict[c] == {pfx, b.data_byte}) begin
                    hit = c;
                    break;
                end
            end
            if (hit >= 0) begin
                pfx = CB'(hit);
            end else begin
                code_q.push_back('{code: pfx, last: 1'b0});
                if (next_code < DSZ) begin
                    dict[next_code] = {pfx, b.data_byte};
                    next_code++;
                end
                pfx = CB'(b.data_byte);
            end
        end
        if (b.eom) begin
            code_q.push_back('{code: pfx, last: 1'b1});
            lzw_clear();
        end
    endtask

    always @(posedge i_clk) begin
        t_byte_in b;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                lzw_predict('{data_byte: i_data_byte, eom: i_end_of_message});
            end
            if (!i_valid || !o_stall) begin
                if (byte_q.size() > 0 && !hold_src &&
                    $urandom_range(99) >= src_idle) begin
                    b = byte_q.pop_front();
                    i_valid <= 1'b1;
                    i_data_byte <= b.data_byte;
                    i_end_of_message <= b.eom;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_code_out e;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (code_q.size() == 0) begin
                    $display("%0t unexpected code: expected none, actual %0d/%0b",
                             $time, o_code_out, o_last_code);
                    errors++;
                end else begin
                    e = code_q.pop_front();
                    if (o_code_out !== e.code) begin
                        $display("%0t code mismatch: expected %0d, actual %0d",
                                 $time, e.code, o_code_out);
                        errors++;
                    end
                    if (o_last_code !== e.last) begin
                        $display("%0t last mismatch: expected %0b, actual %0b",
                                 $time, e.last, o_last_code);
                        errors++;
                    end
                end
            end
            i_stall <= ($urandom_range(99) < snk_idle);
        end
    end

    task automatic add_msg(input int len, input int alpha);
        for (int k = 0; k < len; k++) begin
            byte_q.push_back('{data_byte: 8'($urandom_range(alpha - 1)),
                               eom: (k == len - 1)});
        end
    endtask

    task automatic drain();
        while (byte_q.size() > 0 || i_valid || code_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        lzw_clear();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: single-byte messages at the extremes, repeats, 0xff/0x00
        byte_q.push_back('{8'h00, 1'b1});
        byte_q.push_back('{8'hff, 1'b1});
        for (int k = 0; k < 8; k++) byte_q.push_back('{8'h55, k == 7});
        for (int k = 0; k < 8; k++) byte_q.push_back('{(k[0] ? 8'hff : 8'h00), k == 7});
        byte_q.push_back('{8'haa, 1'b0});
        byte_q.push_back('{8'haa, 1'b1});
        drain();
        for (int p = 0; p < 3; p++) begin
            if (p == 1) begin
                src_idle = 62;
                snk_idle = 35;
            end else if (p == 2) begin
                src_idle = 0;
                snk_idle = 0;
            end
            for (int m = 0; m < 12; m++) begin
                add_msg($urandom_range(1, 30), (m % 3 == 0) ? 256 : $urandom_range(2, 6));
            end
            if (p == 0) begin
                hold_src = 1'b1;
                while (i_valid) @(posedge i_clk);
                while (code_q.size() > 0) @(posedge i_clk);
                hold_src = 1'b0;
            end
            drain();
        end
        // longer messages with long phrases and a wide alphabet, then a short one
        add_msg(150, 4);
        add_msg(20, 256);
        add_msg(5, 3);
        drain();
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #50000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
